>>> rtl/core/fig_pkg.sv
// ----------------------------------------------------------------------------
// Fault injection gate package
// Types, constants and small arithmetic helpers shared by the gate RTL.
// ----------------------------------------------------------------------------
package fig_pkg;

  localparam int MOTOR_COUNT   = 8;
  localparam int I2C_BUS_COUNT = 4;
  localparam int SPI_BUS_COUNT = 4;

  localparam int I2C_IDX_W  = (I2C_BUS_COUNT > 1) ? $clog2(I2C_BUS_COUNT) : 1;
  localparam int SPI_IDX_W  = (SPI_BUS_COUNT > 1) ? $clog2(SPI_BUS_COUNT) : 1;
  localparam int MASK_IDX_W = 3;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;

  localparam logic signed [15:0] KNOB_MIN     = 16'sd1000;
  localparam logic signed [15:0] KNOB_MAX     = 16'sd2000;
  localparam logic signed [15:0] BATT_LOW_TH  = 16'sd1250;
  localparam logic signed [15:0] BATT_HIGH_TH = 16'sd1750;
  localparam logic [9:0]  KNOB_SPAN    = 10'd1000;
  localparam logic [17:0] RECIP_DIV10  = 18'd205;
  localparam logic [26:0] RECIP_DIV100 = 27'd5243;
  localparam logic [6:0]  RATE_FULL    = 7'd100;
  localparam logic [6:0]  CNT_LAST     = 7'd99;
  localparam logic [6:0]  FILL_BASE    = 7'h40;
  localparam logic [13:0] FILL_SPAN    = 14'd63;
  localparam logic [6:0]  MAX_RATE_RST = 7'd100;

  localparam logic [1:0] BATT_NONE = 2'd0;
  localparam logic [1:0] BATT_LOW  = 2'd1;
  localparam logic [1:0] BATT_HIGH = 2'd2;

  typedef enum logic [1:0] {
    REQ_UPDATE   = 2'd0,
    REQ_I2C_READ = 2'd1,
    REQ_SPI_READ = 2'd2,
    REQ_MOTOR    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_I2C_MAX = 2'd0,
    CFG_SPI_MAX = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    req_e              req;
    logic [3:0]        target;
    logic [7:0]        motor_mask;
    logic [7:0]        i2c_mask;
    logic [7:0]        spi_mask;
    logic signed [15:0] i2c_knob;
    logic signed [15:0] spi_knob;
    logic signed [15:0] batt_knob;
    logic              rc_loss;
  } s1_t;

  typedef struct packed {
    req_e       req;
    logic [3:0] target;
    logic [7:0] motor_mask;
    logic [7:0] i2c_mask;
    logic [7:0] spi_mask;
    logic       rc_loss;
    logic [1:0] batt_lvl;
    logic [6:0] i2c_pct;
    logic [6:0] spi_pct;
  } s2_t;

  typedef struct packed {
    req_e        req;
    logic [3:0]  target;
    logic [7:0]  motor_mask;
    logic [7:0]  i2c_mask;
    logic [7:0]  spi_mask;
    logic        rc_loss;
    logic [1:0]  batt_lvl;
    logic [6:0]  spi_pct;
    logic [13:0] i2c_prod;
    logic [13:0] spi_prod;
    logic [13:0] fill_prod;
  } s3_t;

  typedef struct packed {
    logic [6:0] spi_pct;
    logic [6:0] i2c_rate;
    logic       ovr_mode;
    logic       rc_loss;
    logic [1:0] batt_lvl;
    logic       motor_off;
    logic [6:0] fill;
    logic       ovr_act;
    logic       blocked;
  } res_t;

  typedef struct packed {
    logic       blocked;
    logic [6:0] cnt_next;
  } pat_t;

  // Clamp to 1000..2000, then (clamped - 1000) / 10 as a multiply by 205/2048,
  // which is exact over 0..1000.
  function automatic logic [6:0] knob_pct(input logic signed [15:0] knob);
    logic [9:0]         off;
    logic signed [15:0] diff;
    logic [17:0]        prod;
    diff = knob - KNOB_MIN;
    if (knob < KNOB_MIN) begin
      off = '0;
    end else if (knob > KNOB_MAX) begin
      off = KNOB_SPAN;
    end else begin
      off = diff[9:0];
    end
    prod = 18'(off) * RECIP_DIV10;
    return prod[17:11];
  endfunction

  function automatic logic [1:0] batt_level(input logic signed [15:0] knob);
    logic [1:0] lvl;
    if (knob < BATT_LOW_TH) begin
      lvl = BATT_NONE;
    end else if (knob <= BATT_HIGH_TH) begin
      lvl = BATT_LOW;
    end else begin
      lvl = BATT_HIGH;
    end
    return lvl;
  endfunction

  // Division by 100 as a multiply by 5243/2^19, exact for values up to 12700.
  function automatic logic [6:0] div100(input logic [13:0] val);
    logic [26:0] prod;
    prod = 27'(val) * RECIP_DIV100;
    return prod[25:19];
  endfunction

  // One step of the repeating block pattern for a single bus.
  function automatic pat_t pattern_step(input logic en, input logic [6:0] rate,
                                        input logic [6:0] cnt);
    pat_t r;
    r.blocked  = 1'b0;
    r.cnt_next = cnt;
    if (en && (rate != '0)) begin
      if (rate >= RATE_FULL) begin
        r.blocked = 1'b1;
      end else begin
        r.blocked  = (cnt < rate);
        r.cnt_next = (cnt == CNT_LAST) ? '0 : cnt + 7'd1;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/fault_injection_gate.sv
// ----------------------------------------------------------------------------
// Fault injection gate
// Knob updates set fault rates and levels; bus and motor queries are answered
// from that state with a per-bus repeating block pattern.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transaction: tuser is the request kind
//   (update, I2C read, SPI read, motor query), tdata the target and knobs.
//   m_axis returns exactly one result per request, in request order.
//   cfg writes the two max error rate registers; write them only while no
//   request is in flight. Rates are derived from them at the next update.
// Timing:
//   Four register stages (input, percent, product, result); a request
//   passes through them in order before its result shows on m_axis.
//   One request per cycle is sustained while m_axis_tready_i is high;
//   the result stage (divide by 100, bus counter update) is the longest path.
// Reset:
//   Both max error rates return to 100, the fill byte returns to 0x40, all
//   other fault state and bus counters clear, and the pipeline empties.
// Stall:
//   When m_axis_tready_i is low the result holds and the requests behind it
//   close up; s_axis_tready_o drops only once all four stages hold a request.
// ----------------------------------------------------------------------------
module fault_injection_gate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Fields from bit 0: target[3:0], motor_mask_in[11:4], i2c_mask_in[19:12],
  // i2c_knob[35:20], spi_mask_in[43:36], spi_knob[59:44],
  // battery_knob[75:60], rc_loss_request[76], zero fill up to bit 79.
  input  logic [fig_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // Fields from bit 0: req_type[1:0].
  input  logic [1:0]                      s_axis_tuser_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // Fields from bit 0: read_blocked[0], overrange_active[1], fill_byte[8:2],
  // motor_disabled[9], battery_level[11:10], rc_loss_active[12],
  // overrange_mode[13], i2c_rate_now[20:14], spi_percent_now[27:21],
  // zero fill up to bit 31.
  output logic [fig_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [6:0]                      cfg_data_i
);

  // Configuration registers.
  logic [6:0] i2c_max_q, spi_max_q;

  // Pipeline registers.
  logic         s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  fig_pkg::s1_t s1_d, s1_q;
  fig_pkg::s2_t s2_d, s2_q;
  fig_pkg::s3_t s3_d, s3_q;
  fig_pkg::res_t res_d, res_q;
  logic         out_ready, s3_ready, s2_ready, s1_ready, s3_fire;

  // Fault state.
  logic [7:0] motor_off_d, motor_off_q;
  logic [7:0] i2c_en_d, i2c_en_q;
  logic [7:0] spi_en_d, spi_en_q;
  logic [6:0] i2c_rate_d, i2c_rate_q;
  logic [6:0] spi_rate_d, spi_rate_q;
  logic [6:0] spi_pct_d, spi_pct_q;
  logic [6:0] fill_d, fill_q;
  logic       ovr_d, ovr_q;
  logic       sw_last_d, sw_last_q;
  logic [1:0] batt_d, batt_q;
  logic       rc_d, rc_q;
  logic [6:0] i2c_cnt_d [fig_pkg::I2C_BUS_COUNT];
  logic [6:0] i2c_cnt_q [fig_pkg::I2C_BUS_COUNT];
  logic [6:0] spi_cnt_d [fig_pkg::SPI_BUS_COUNT];
  logic [6:0] spi_cnt_q [fig_pkg::SPI_BUS_COUNT];

  logic [fig_pkg::I2C_IDX_W-1:0]  i2c_idx;
  logic [fig_pkg::SPI_IDX_W-1:0]  spi_idx;
  logic [fig_pkg::MASK_IDX_W-1:0] bit_idx;
  logic                           i2c_hit, spi_hit, motor_hit;
  fig_pkg::pat_t                  i2c_pat, spi_pat;

  // Configuration port.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i2c_max_q <= fig_pkg::MAX_RATE_RST;
      spi_max_q <= fig_pkg::MAX_RATE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fig_pkg::CFG_I2C_MAX: i2c_max_q <= cfg_data_i;
        fig_pkg::CFG_SPI_MAX: spi_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake chain: each stage moves when the one after it has room.
  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign s3_ready        = !s3_valid_q || out_ready;
  assign s2_ready        = !s2_valid_q || s3_ready;
  assign s1_ready        = !s1_valid_q || s2_ready;
  assign s3_fire         = s3_valid_q && out_ready;
  assign s_axis_tready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= s_axis_tvalid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // Stage 1: unpack the request.
  always_comb begin
    s1_d.req        = fig_pkg::req_e'(s_axis_tuser_i);
    s1_d.target     = s_axis_tdata_i[3:0];
    s1_d.motor_mask = s_axis_tdata_i[11:4];
    s1_d.i2c_mask   = s_axis_tdata_i[19:12];
    s1_d.i2c_knob   = $signed(s_axis_tdata_i[35:20]);
    s1_d.spi_mask   = s_axis_tdata_i[43:36];
    s1_d.spi_knob   = $signed(s_axis_tdata_i[59:44]);
    s1_d.batt_knob  = $signed(s_axis_tdata_i[75:60]);
    s1_d.rc_loss    = s_axis_tdata_i[76];
  end

  // Stage 2: clamp the bus knobs and turn them into percents; grade the battery knob.
  always_comb begin
    s2_d.req        = s1_q.req;
    s2_d.target     = s1_q.target;
    s2_d.motor_mask = s1_q.motor_mask;
    s2_d.i2c_mask   = s1_q.i2c_mask;
    s2_d.spi_mask   = s1_q.spi_mask;
    s2_d.rc_loss    = s1_q.rc_loss;
    s2_d.batt_lvl   = fig_pkg::batt_level(s1_q.batt_knob);
    s2_d.i2c_pct    = fig_pkg::knob_pct(s1_q.i2c_knob);
    s2_d.spi_pct    = fig_pkg::knob_pct(s1_q.spi_knob);
  end

  // Stage 3: scale the percents by the max rates and by the fill span.
  always_comb begin
    s3_d.req        = s2_q.req;
    s3_d.target     = s2_q.target;
    s3_d.motor_mask = s2_q.motor_mask;
    s3_d.i2c_mask   = s2_q.i2c_mask;
    s3_d.spi_mask   = s2_q.spi_mask;
    s3_d.rc_loss    = s2_q.rc_loss;
    s3_d.batt_lvl   = s2_q.batt_lvl;
    s3_d.spi_pct    = s2_q.spi_pct;
    s3_d.i2c_prod   = 14'(s2_q.i2c_pct) * 14'(i2c_max_q);
    s3_d.spi_prod   = 14'(s2_q.spi_pct) * 14'(spi_max_q);
    s3_d.fill_prod  = 14'(s2_q.spi_pct) * fig_pkg::FILL_SPAN;
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s1_ready) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q && s2_ready) begin
      s2_q <= s2_d;
    end
    if (s2_valid_q && s3_ready) begin
      s3_q <= s3_d;
    end
    if (s3_fire) begin
      res_q <= res_d;
    end
  end

  // Final stage: apply the request to the fault state and form the result.
  assign i2c_idx   = s3_q.target[fig_pkg::I2C_IDX_W-1:0];
  assign spi_idx   = s3_q.target[fig_pkg::SPI_IDX_W-1:0];
  assign bit_idx   = s3_q.target[fig_pkg::MASK_IDX_W-1:0];
  assign i2c_hit   = (s3_q.target < 4'(fig_pkg::I2C_BUS_COUNT));
  assign spi_hit   = (s3_q.target < 4'(fig_pkg::SPI_BUS_COUNT));
  assign motor_hit = (s3_q.target < 4'(fig_pkg::MOTOR_COUNT));
  assign i2c_pat   = fig_pkg::pattern_step(i2c_en_q[bit_idx], i2c_rate_q,
                                           i2c_cnt_q[i2c_idx]);
  assign spi_pat   = fig_pkg::pattern_step(spi_en_q[bit_idx], spi_rate_q,
                                           spi_cnt_q[spi_idx]);

  always_comb begin
    motor_off_d = motor_off_q;
    i2c_en_d    = i2c_en_q;
    spi_en_d    = spi_en_q;
    i2c_rate_d  = i2c_rate_q;
    spi_rate_d  = spi_rate_q;
    spi_pct_d   = spi_pct_q;
    fill_d      = fill_q;
    ovr_d       = ovr_q;
    sw_last_d   = sw_last_q;
    batt_d      = batt_q;
    rc_d        = rc_q;
    i2c_cnt_d   = i2c_cnt_q;
    spi_cnt_d   = spi_cnt_q;
    res_d       = '0;

    unique case (s3_q.req)
      fig_pkg::REQ_UPDATE: begin
        motor_off_d = s3_q.motor_mask;
        i2c_en_d    = s3_q.i2c_mask;
        spi_en_d    = s3_q.spi_mask;
        i2c_rate_d  = fig_pkg::div100(s3_q.i2c_prod);
        spi_rate_d  = fig_pkg::div100(s3_q.spi_prod);
        spi_pct_d   = s3_q.spi_pct;
        fill_d      = fig_pkg::FILL_BASE + fig_pkg::div100(s3_q.fill_prod);
        // The SPI switch going from on to off with the knob at its bottom
        // flips between error-rate mode and overrange mode.
        if (sw_last_q && (s3_q.spi_mask == '0) && (s3_q.spi_pct == '0)) begin
          ovr_d = !ovr_q;
        end
        sw_last_d = |s3_q.spi_mask;
        batt_d    = s3_q.batt_lvl;
        rc_d      = s3_q.rc_loss;
      end
      fig_pkg::REQ_I2C_READ: begin
        if (i2c_hit) begin
          res_d.blocked      = i2c_pat.blocked;
          i2c_cnt_d[i2c_idx] = i2c_pat.cnt_next;
        end
      end
      fig_pkg::REQ_SPI_READ: begin
        if (spi_hit) begin
          if (!ovr_q) begin
            res_d.blocked      = spi_pat.blocked;
            spi_cnt_d[spi_idx] = spi_pat.cnt_next;
          end else begin
            res_d.ovr_act = spi_en_q[bit_idx];
          end
        end
      end
      fig_pkg::REQ_MOTOR: begin
        if (motor_hit) begin
          res_d.motor_off = motor_off_q[bit_idx];
        end
      end
      default: ;
    endcase

    res_d.fill     = fill_d;
    res_d.batt_lvl = batt_d;
    res_d.rc_loss  = rc_d;
    res_d.ovr_mode = ovr_d;
    res_d.i2c_rate = i2c_rate_d;
    res_d.spi_pct  = spi_pct_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_off_q <= '0;
      i2c_en_q    <= '0;
      spi_en_q    <= '0;
      i2c_rate_q  <= '0;
      spi_rate_q  <= '0;
      spi_pct_q   <= '0;
      fill_q      <= fig_pkg::FILL_BASE;
      ovr_q       <= 1'b0;
      sw_last_q   <= 1'b0;
      batt_q      <= fig_pkg::BATT_NONE;
      rc_q        <= 1'b0;
      i2c_cnt_q   <= '{default: '0};
      spi_cnt_q   <= '{default: '0};
    end else if (s3_fire) begin
      motor_off_q <= motor_off_d;
      i2c_en_q    <= i2c_en_d;
      spi_en_q    <= spi_en_d;
      i2c_rate_q  <= i2c_rate_d;
      spi_rate_q  <= spi_rate_d;
      spi_pct_q   <= spi_pct_d;
      fill_q      <= fill_d;
      ovr_q       <= ovr_d;
      sw_last_q   <= sw_last_d;
      batt_q      <= batt_d;
      rc_q        <= rc_d;
      i2c_cnt_q   <= i2c_cnt_d;
      spi_cnt_q   <= spi_cnt_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, res_q};

`ifndef SYNTHESIS
  a_batt_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (batt_q == fig_pkg::BATT_NONE) || (batt_q == fig_pkg::BATT_LOW) ||
    (batt_q == fig_pkg::BATT_HIGH))
    else $error("battery fault level out of range");

  a_fill_high_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[6])
    else $error("fill byte below its base value");

  a_ovr_not_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.ovr_act && res_q.blocked))
    else $error("overrange SPI read reported as blocked");

  a_ovr_only_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovr_q != $past(ovr_q)) |-> $past(s3_fire && (s3_q.req == fig_pkg::REQ_UPDATE)))
    else $error("overrange mode changed outside a knob update");
`endif

endmodule
